/* design/ncs_pkg.sv */
`timescale 1ns / 1ps

package ncs_pkg;

  // Scanner phases.
  typedef enum logic [2:0] {
    PH_IDLE  = 3'd0,
    PH_SKIP  = 3'd1,
    PH_STAR  = 3'd2,
    PH_FIRST = 3'd3,
    PH_BODY  = 3'd4,
    PH_LPAR  = 3'd5,
    PH_AST   = 3'd6
  } phase_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_IDLE    = 3'd0,
    ST_PEND    = 3'd1,
    ST_COMMENT = 3'd2,
    ST_PRAGMA  = 3'd3,
    ST_NOMATCH = 3'd4,
    ST_OVER    = 3'd5
  } status_e;

  // Character codes.
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_VT     = 8'h0B;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_CR     = 8'h0D;

  localparam int unsigned TokLenW = 16;

  // One input beat.
  typedef struct packed {
    logic       start_req;
    logic       allow_comment;
    logic       allow_pragma;
    logic       at_end;
    logic [7:0] char_in;
  } in_item_t;

  // One result beat.
  typedef struct packed {
    logic [2:0]         status;
    logic [TokLenW-1:0] token_length;
  } out_item_t;

  // Whitespace skipped ahead of the opener.
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_LF) ||
           (c == CH_CR) || (c == CH_VT) || (c == CH_FF);
  endfunction

endpackage

/* design/ncs_stream_if.sv */
`timescale 1ns / 1ps

// Valid/ready channel; one beat moves when both are high at a clock edge.
interface ncs_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* design/ncs_step.sv */
`timescale 1ns / 1ps

module ncs_step #(
  parameter int unsigned MAX_DEPTH = 255,
  parameter int unsigned LEN_BITS  = 16
) (
  input  ncs_pkg::in_item_t                      item_i,
  input  ncs_pkg::phase_e                        phase_i,
  input  logic [$clog2(MAX_DEPTH+1)-1:0]         depth_i,
  input  logic                                   pragma_i,
  input  logic [LEN_BITS-1:0]                    length_i,
  output ncs_pkg::phase_e                        phase_o,
  output logic [$clog2(MAX_DEPTH+1)-1:0]         depth_o,
  output logic                                   pragma_o,
  output logic [LEN_BITS-1:0]                    length_o,
  output ncs_pkg::out_item_t                     result_o
);
  import ncs_pkg::*;

  localparam int unsigned DepthW = $clog2(MAX_DEPTH + 1);
  localparam int unsigned ExtW   = (LEN_BITS > TokLenW) ? LEN_BITS : TokLenW;

  logic                start_fail;
  phase_e              phase0;
  logic [DepthW-1:0]   depth0;
  logic [DepthW-1:0]   depth_dec;
  logic                pragma0;
  logic [LEN_BITS-1:0] len0;
  logic [LEN_BITS-1:0] len_inc;
  logic [ExtW-1:0]     len_ext;
  logic [TokLenW-1:0]  len_sat;
  logic                depth_full;
  logic [7:0]          c;
  status_e             status;

  // A start beat drops any running attempt and opens a fresh one if comments or pragmas are allowed.
  always_comb begin
    c          = item_i.char_in;
    start_fail = item_i.start_req && !(item_i.allow_comment || item_i.allow_pragma);
    if (item_i.start_req) begin
      phase0  = (item_i.allow_comment || item_i.allow_pragma) ? PH_SKIP : PH_IDLE;
      depth0  = '0;
      pragma0 = 1'b0;
      len0    = '0;
    end else begin
      phase0  = phase_i;
      depth0  = depth_i;
      pragma0 = pragma_i;
      len0    = length_i;
    end
  end

  // Shared arithmetic: saturating length bump, depth step and reported length.
  always_comb begin
    len_inc    = (len0 == '1) ? len0 : len0 + LEN_BITS'(1);
    depth_dec  = (depth0 != '0) ? depth0 - DepthW'(1) : '0;
    depth_full = (depth0 >= DepthW'(MAX_DEPTH));
    len_ext    = ExtW'(len_inc);
    len_sat    = (len_ext > ExtW'({TokLenW{1'b1}})) ? {TokLenW{1'b1}} : len_ext[TokLenW-1:0];
  end

  // Next-state logic.
  always_comb begin
    phase_o  = phase0;
    depth_o  = depth0;
    pragma_o = pragma0;
    length_o = len0;
    if (start_fail || item_i.at_end) begin
      phase_o = PH_IDLE;
    end else begin
      unique case (phase0)
        PH_SKIP: begin
          if (is_blank(c)) begin
            phase_o = PH_SKIP;
          end else if (c == CH_LPAREN) begin
            length_o = LEN_BITS'(1);
            phase_o  = PH_STAR;
          end else begin
            phase_o = PH_IDLE;
          end
        end
        PH_STAR: begin
          if (c == CH_STAR) begin
            length_o = len_inc;
            depth_o  = DepthW'(1);
            phase_o  = PH_FIRST;
          end else begin
            phase_o = PH_IDLE;
          end
        end
        PH_FIRST, PH_BODY, PH_LPAR, PH_AST: begin
          if (phase0 == PH_FIRST) begin
            pragma_o = (c == CH_DOLLAR);
          end
          if (phase0 == PH_LPAR && c == CH_STAR) begin
            // Nested opener.
            length_o = len_inc;
            if (depth_full) begin
              phase_o = PH_IDLE;
            end else begin
              depth_o = depth0 + DepthW'(1);
              phase_o = PH_BODY;
            end
          end else if (phase0 == PH_AST && c == CH_RPAREN) begin
            // Closer.
            length_o = len_inc;
            depth_o  = depth_dec;
            phase_o  = (depth_dec == '0) ? PH_IDLE : PH_BODY;
          end else begin
            // Ordinary body byte; a lone '(' or '*' may start a pair.
            length_o = len_inc;
            if (c == CH_LPAREN) begin
              phase_o = PH_LPAR;
            end else if (c == CH_STAR) begin
              phase_o = PH_AST;
            end else begin
              phase_o = PH_BODY;
            end
          end
        end
        default: begin
          phase_o = PH_IDLE;
        end
      endcase
    end
  end

  // Result logic.
  always_comb begin
    status               = ST_PEND;
    result_o.token_length = '0;
    if (start_fail) begin
      status = ST_NOMATCH;
    end else if (phase0 == PH_IDLE || phase0 > PH_AST) begin
      status = ST_IDLE;
    end else if (item_i.at_end) begin
      status = ST_NOMATCH;
    end else begin
      unique case (phase0)
        PH_SKIP: begin
          if (!is_blank(c) && c != CH_LPAREN) begin
            status = ST_NOMATCH;
          end
        end
        PH_STAR: begin
          if (c != CH_STAR) begin
            status = ST_NOMATCH;
          end
        end
        PH_LPAR: begin
          if (c == CH_STAR && depth_full) begin
            status = ST_OVER;
          end
        end
        PH_AST: begin
          if (c == CH_RPAREN && depth_dec == '0) begin
            status                = pragma0 ? ST_PRAGMA : ST_COMMENT;
            result_o.token_length = len_sat;
          end
        end
        default: begin
          status = ST_PEND;
        end
      endcase
    end
    result_o.status = status;
  end

endmodule

/* design/nested_comment_scanner.sv */
// Nested block-comment scanner, one character per beat.
// An accepted input beat waits in the input register until the scan logic fires into the result register.
// Throughput: one beat per cycle; an input register and a result register
// bracket a single stage of scan logic, so the result channel alone stalls it.
// Reset (rst_ni low, asynchronous): scanner idle, depth, pragma and length cleared.
`timescale 1ns / 1ps

module nested_comment_scanner #(
  parameter int unsigned MAX_DEPTH = 255,
  parameter int unsigned LEN_BITS  = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  ncs_stream_if.sink       in_i,
  ncs_stream_if.source     out_o
);
  import ncs_pkg::*;

  localparam int unsigned DepthW = $clog2(MAX_DEPTH + 1);

  logic                in_valid_q;
  in_item_t            in_data_q;
  logic                out_valid_q;
  out_item_t           out_data_q;
  logic                out_free;
  logic                fire;
  logic                in_take;

  phase_e              phase_q, phase_d;
  logic [DepthW-1:0]   depth_q, depth_d;
  logic                pragma_q, pragma_d;
  logic [LEN_BITS-1:0] length_q, length_d;
  out_item_t           result;

  // Handshake: the input register refills while the result register drains.
  assign out_free    = !out_valid_q || out_o.ready;
  assign fire        = in_valid_q && out_free;
  assign in_i.ready  = !in_valid_q || out_free;
  assign in_take     = in_i.valid && in_i.ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  ncs_step #(
    .MAX_DEPTH (MAX_DEPTH),
    .LEN_BITS  (LEN_BITS)
  ) u_step (
    .item_i   (in_data_q),
    .phase_i  (phase_q),
    .depth_i  (depth_q),
    .pragma_i (pragma_q),
    .length_i (length_q),
    .phase_o  (phase_d),
    .depth_o  (depth_d),
    .pragma_o (pragma_d),
    .length_o (length_d),
    .result_o (result)
  );

  // Control flags and scanner state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      phase_q     <= PH_IDLE;
      depth_q     <= '0;
      pragma_q    <= 1'b0;
      length_q    <= '0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (fire) begin
        in_valid_q <= 1'b0;
      end
      if (fire) begin
        out_valid_q <= 1'b1;
        phase_q     <= phase_d;
        depth_q     <= depth_d;
        pragma_q    <= pragma_d;
        length_q    <= length_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_data_q <= in_i.data;
    end
    if (fire) begin
      out_data_q <= result;
    end
  end

  // Nesting depth never passes the configured limit.
  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    depth_q <= DepthW'(MAX_DEPTH))
    else $error("nesting depth above limit");

  // Inside a comment body at least one opener is open.
  a_depth_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_FIRST || phase_q == PH_BODY || phase_q == PH_LPAR ||
     phase_q == PH_AST) |-> (depth_q != '0))
    else $error("body phase with zero depth");

  // A match covers at least an opener and a closer; anything else reports zero length.
  a_match_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |->
      (((out_data_q.status == ST_COMMENT) || (out_data_q.status == ST_PRAGMA))
        ? (out_data_q.token_length >= TokLenW'(4))
        : (out_data_q.token_length == '0)))
    else $error("token length inconsistent with status");

endmodule
